@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL. Define ASSERT_OFF to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

@@ rtl/fgsc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package fgsc_pkg;

   localparam int DVS_W = 10;
   localparam int QUO_W = 8;
   localparam int DVD_W = DVS_W + QUO_W - 1;
   localparam int CNT_W = $clog2(QUO_W);

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_rsp_type;

endpackage
`default_nettype wire

@@ rtl/fgsc_serial_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
module fgsc_serial_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire fgsc_pkg::div_req_type div_req,
   output fgsc_pkg::div_rsp_type     div_rsp
);

   logic [fgsc_pkg::DVD_W-1:0] rem_ff, rem_in;
   logic [fgsc_pkg::DVD_W-1:0] dsh_ff, dsh_in;
   logic [fgsc_pkg::QUO_W-1:0] quo_ff, quo_in;
   logic [fgsc_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;

   // Restoring division, one quotient bit per cycle from the top bit down.
   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = div_req.dividend;
         dsh_in  = {div_req.divisor, {(fgsc_pkg::QUO_W-1){1'b0}}};
         quo_in  = '0;
         cnt_in  = fgsc_pkg::CNT_W'(fgsc_pkg::QUO_W-1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= dsh_ff) begin
            rem_in = rem_ff - dsh_ff;
            quo_in = {quo_ff[fgsc_pkg::QUO_W-2:0], 1'b1};
         end else begin
            quo_in = {quo_ff[fgsc_pkg::QUO_W-2:0], 1'b0};
         end
         dsh_in = dsh_ff >> 1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - fgsc_pkg::CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule
`default_nettype wire

@@ rtl/finger_grip_servo_control_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Finger grip servo controller.
// The req_ channel carries one word per item: a position command (opcode 0) with a
// requested percent, or a step tick (opcode 1); both carry the current pressure sample.
// Every accepted word gives exactly one rsp_ word: drive angle, position percent,
// pressure percent and the closing flag, all taken after the update.
// The csr_ port writes the angle span, the pressure span and the sensor flag; the user
// must write it only while the block is idle, as the block itself does not enforce this.
// One word is worked on at a time: a new word is taken only after the last result has
// been placed in the output register. The single bit-serial divider is shared; it runs
// 8 steps for the target angle of a command and 8 steps each for the two percent results.
// The result sits in an output register, so the next word is processed while a
// stalled result waits; a finished word waits only if that register is still full.
// Reset clears the finger to angle 0, ends any close and loads the register defaults:
// span 0 to 180 degrees, pressure span 0 to 1023, no sensor fitted.
`include "assert_macros.svh"
module finger_grip_servo_control_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_opcode,
   input  wire logic [7:0] req_percent_request,
   input  wire logic [9:0] req_pressure_sample,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_drive_angle,
   output logic [6:0]      rsp_position_percent,
   output logic [6:0]      rsp_pressure_percent,
   output logic            rsp_closing,
   input  wire logic       csr_write,
   input  wire logic [2:0] csr_index,
   input  wire logic [9:0] csr_data
);

   localparam logic [2:0] CSR_MIN_ANGLE    = 3'd0;
   localparam logic [2:0] CSR_MAX_ANGLE    = 3'd1;
   localparam logic [2:0] CSR_SENSOR       = 3'd2;
   localparam logic [2:0] CSR_MIN_PRESSURE = 3'd3;
   localparam logic [2:0] CSR_MAX_PRESSURE = 3'd4;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_PREP   = 3'd1;
   localparam logic [2:0] S_TGT    = 3'd2;
   localparam logic [2:0] S_PSTART = 3'd3;
   localparam logic [2:0] S_POS    = 3'd4;
   localparam logic [2:0] S_PRS    = 3'd5;
   localparam logic [2:0] S_OUT    = 3'd6;

   localparam logic       OP_COMMAND = 1'b0;
   localparam logic [6:0] PCT_FULL   = 7'd100;
   localparam logic [9:0] TGT_DIVISOR = 10'd100;

   typedef struct packed {
      logic                                 zero;
      logic                                 sat;
      logic [fgsc_pkg::DVD_W-1:0]           dividend;
      logic [fgsc_pkg::DVS_W-1:0]           divisor;
   } pct_op_type;

   // Sets up num * 100 / span as a division of magnitudes; a result of the wrong sign
   // clamps to zero and one of a hundred or more is known before dividing.
   function automatic pct_op_type pct_setup(input logic signed [10:0] num,
                                            input logic signed [10:0] span);
      pct_op_type                 op;
      logic [9:0]                 mn_w;
      logic [9:0]                 ms_w;
      logic [fgsc_pkg::DVD_W-1:0] mn_x;
      mn_w = num[10] ? 10'(-num) : num[9:0];
      ms_w = span[10] ? 10'(-span) : span[9:0];
      mn_x = fgsc_pkg::DVD_W'(mn_w);
      op.zero     = (span == '0) || (num == '0) || (num[10] != span[10]);
      op.sat      = mn_w >= ms_w;
      op.dividend = (mn_x << 6) + (mn_x << 5) + (mn_x << 2);
      op.divisor  = ms_w;
      return op;
   endfunction

   logic [7:0] min_angle_ff, min_angle_in;
   logic [7:0] max_angle_ff, max_angle_in;
   logic       sensor_ff, sensor_in;
   logic [9:0] min_prs_ff, min_prs_in;
   logic [9:0] max_prs_ff, max_prs_in;

   logic [2:0] state_ff, state_in;
   logic       opcode_ff, opcode_in;
   logic [6:0] pct_ff, pct_in;
   logic [9:0] sample_ff, sample_in;
   logic [7:0] current_angle_ff, current_angle_in;
   logic [7:0] goal_angle_ff, goal_angle_in;
   logic       closing_ff, closing_in;
   logic       zero_ff, zero_in;
   logic       sat_ff, sat_in;
   logic [6:0] pos_pct_ff, pos_pct_in;
   logic [6:0] prs_pct_ff, prs_pct_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_angle_ff, rsp_angle_in;
   logic [6:0] rsp_pos_ff, rsp_pos_in;
   logic [6:0] rsp_prs_ff, rsp_prs_in;
   logic       rsp_closing_ff, rsp_closing_in;

   fgsc_pkg::div_req_type div_req;
   fgsc_pkg::div_rsp_type div_rsp;

   logic        span_neg;
   logic [7:0]  span_mag;
   logic [14:0] tgt_prod;
   logic [7:0]  target;
   logic [7:0]  step_angle;
   logic [6:0]  pct_result;
   pct_op_type  pos_op;
   pct_op_type  prs_op;

   assign span_neg = max_angle_ff < min_angle_ff;
   assign span_mag = span_neg ? (min_angle_ff - max_angle_ff) : (max_angle_ff - min_angle_ff);
   assign tgt_prod = {7'b0, span_mag} * {8'b0, pct_ff};
   assign target   = span_neg ? (min_angle_ff - div_rsp.quotient)
                              : (min_angle_ff + div_rsp.quotient);
   assign step_angle = (current_angle_ff < goal_angle_ff) ? (current_angle_ff + 8'd1)
                                                          : current_angle_ff;
   assign pct_result = zero_ff ? 7'd0 : (sat_ff ? PCT_FULL : div_rsp.quotient[6:0]);

   assign pos_op = pct_setup(11'({3'b0, current_angle_ff}) - 11'({3'b0, min_angle_ff}),
                             11'({3'b0, max_angle_ff}) - 11'({3'b0, min_angle_ff}));
   assign prs_op = pct_setup(11'({1'b0, sample_ff}) - 11'({1'b0, min_prs_ff}),
                             11'({1'b0, max_prs_ff}) - 11'({1'b0, min_prs_ff}));

   always_comb begin
      min_angle_in = min_angle_ff;
      max_angle_in = max_angle_ff;
      sensor_in    = sensor_ff;
      min_prs_in   = min_prs_ff;
      max_prs_in   = max_prs_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_MIN_ANGLE:    min_angle_in = csr_data[7:0];
            CSR_MAX_ANGLE:    max_angle_in = csr_data[7:0];
            CSR_SENSOR:       sensor_in    = csr_data[0];
            CSR_MIN_PRESSURE: min_prs_in   = csr_data;
            CSR_MAX_PRESSURE: max_prs_in   = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in         = state_ff;
      opcode_in        = opcode_ff;
      pct_in           = pct_ff;
      sample_in        = sample_ff;
      current_angle_in = current_angle_ff;
      goal_angle_in    = goal_angle_ff;
      closing_in       = closing_ff;
      zero_in          = zero_ff;
      sat_in           = sat_ff;
      pos_pct_in       = pos_pct_ff;
      prs_pct_in       = prs_pct_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_angle_in     = rsp_angle_ff;
      rsp_pos_in       = rsp_pos_ff;
      rsp_prs_in       = rsp_prs_ff;
      rsp_closing_in   = rsp_closing_ff;
      div_req.start    = 1'b0;
      div_req.dividend = {2'b0, tgt_prod};
      div_req.divisor  = TGT_DIVISOR;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               opcode_in = req_opcode;
               pct_in    = (req_percent_request > 8'd100) ? PCT_FULL : req_percent_request[6:0];
               sample_in = req_pressure_sample;
               state_in  = S_PREP;
            end
         end
         S_PREP: begin
            if (opcode_ff == OP_COMMAND) begin
               div_req.start = 1'b1;
               state_in      = S_TGT;
            end else begin
               if (closing_ff) begin
                  if (sample_ff >= max_prs_ff) begin
                     closing_in = 1'b0;
                  end else begin
                     current_angle_in = step_angle;
                     if (step_angle >= goal_angle_ff) begin
                        closing_in = 1'b0;
                     end
                  end
               end
               state_in = S_PSTART;
            end
         end
         S_TGT: begin
            if (div_rsp.done) begin
               if ((target <= current_angle_ff) || !sensor_ff) begin
                  current_angle_in = target;
                  closing_in       = 1'b0;
               end else begin
                  goal_angle_in = target;
                  closing_in    = 1'b1;
               end
               state_in = S_PSTART;
            end
         end
         S_PSTART: begin
            div_req.start    = 1'b1;
            div_req.dividend = pos_op.dividend;
            div_req.divisor  = pos_op.divisor;
            zero_in          = pos_op.zero;
            sat_in           = pos_op.sat;
            state_in         = S_POS;
         end
         S_POS: begin
            div_req.dividend = prs_op.dividend;
            div_req.divisor  = prs_op.divisor;
            if (div_rsp.done) begin
               pos_pct_in    = pct_result;
               div_req.start = 1'b1;
               zero_in       = prs_op.zero;
               sat_in        = prs_op.sat;
               state_in      = S_PRS;
            end
         end
         S_PRS: begin
            if (div_rsp.done) begin
               prs_pct_in = pct_result;
               state_in   = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_angle_in   = current_angle_ff;
               rsp_pos_in     = pos_pct_ff;
               rsp_prs_in     = prs_pct_ff;
               rsp_closing_in = closing_ff;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      opcode_ff      <= opcode_in;
      pct_ff         <= pct_in;
      sample_ff      <= sample_in;
      zero_ff        <= zero_in;
      sat_ff         <= sat_in;
      pos_pct_ff     <= pos_pct_in;
      prs_pct_ff     <= prs_pct_in;
      rsp_angle_ff   <= rsp_angle_in;
      rsp_pos_ff     <= rsp_pos_in;
      rsp_prs_ff     <= rsp_prs_in;
      rsp_closing_ff <= rsp_closing_in;
      if (reset) begin
         min_angle_ff     <= 8'd0;
         max_angle_ff     <= 8'd180;
         sensor_ff        <= 1'b0;
         min_prs_ff       <= 10'd0;
         max_prs_ff       <= 10'd1023;
         state_ff         <= S_IDLE;
         current_angle_ff <= 8'd0;
         goal_angle_ff    <= 8'd0;
         closing_ff       <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         min_angle_ff     <= min_angle_in;
         max_angle_ff     <= max_angle_in;
         sensor_ff        <= sensor_in;
         min_prs_ff       <= min_prs_in;
         max_prs_ff       <= max_prs_in;
         state_ff         <= state_in;
         current_angle_ff <= current_angle_in;
         goal_angle_ff    <= goal_angle_in;
         closing_ff       <= closing_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   fgsc_serial_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_stall            = state_ff != S_IDLE;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_drive_angle      = rsp_angle_ff;
   assign rsp_position_percent = rsp_pos_ff;
   assign rsp_pressure_percent = rsp_prs_ff;
   assign rsp_closing          = rsp_closing_ff;

   // A close in progress always has somewhere left to go.
   `ASSERT_CLK(a_close_below_goal, clock, reset, closing_ff |-> (current_angle_ff < goal_angle_ff), "closing with the finger at or past its goal")
   // The divider only finishes while the sequencer is waiting for it.
   `ASSERT_CLK(a_div_done_waited, clock, reset, div_rsp.done |-> (state_ff == S_TGT || state_ff == S_POS || state_ff == S_PRS), "divider result arrived outside a wait state")
   // Both percent results are clamped to a hundred.
   `ASSERT_NEVER(a_pct_clamped, clock, reset, rsp_valid_ff && (rsp_pos_ff > PCT_FULL || rsp_prs_ff > PCT_FULL), "percent result above a hundred")

endmodule
`default_nettype wire
